@@ src/lgge_pkg.sv @@
// ----------------------------------------------------------------------------
// lgge_pkg
// Shared types and constants of the life grid generation engine.
// ----------------------------------------------------------------------------
package lgge_pkg;

  // Field and register widths
  localparam int CmdW    = 2;
  localparam int IdxW    = 6;
  localparam int CountW  = 7;
  localparam int ApbDataW = 32;
  localparam int ApbAddrW = 3;

  // Default grid size
  localparam int MaxRowsDef = 64;
  localparam int MaxColsDef = 64;

  // Reset values of the size registers
  localparam logic [CountW-1:0] RowCountRst = CountW'(64);
  localparam logic [CountW-1:0] ColCountRst = CountW'(64);

  // Register indexes
  localparam logic RegRowCount = 1'b0;
  localparam logic RegColCount = 1'b1;

  // Item commands
  typedef enum logic [CmdW-1:0] {
    CMD_WRITE   = 2'd0,
    CMD_ADVANCE = 2'd1,
    CMD_READ    = 2'd2
  } cmd_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_ADV_FILL,
    ST_ADV_ROW
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic clr_step;
    logic in_take;
    logic acc_write;
    logic acc_read;
    logic adv_start;
    logic adv_fill;
    logic adv_row;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clr_last;
    logic rows_zero;
    logic row_last;
    logic out_busy;
  } dp_stat_t;

endpackage

@@ src/lgge_in_if.sv @@
// ----------------------------------------------------------------------------
// lgge_in_if
// Input item channel: command, cell address and write value.
// ----------------------------------------------------------------------------
interface lgge_in_if;
  import lgge_pkg::*;

  logic            valid;
  logic            ready;
  logic [CmdW-1:0] cmd;
  logic [IdxW-1:0] row_index;
  logic [IdxW-1:0] col_index;
  logic            cell_in;

  modport source (output valid, cmd, row_index, col_index, cell_in, input ready);
  modport sink   (input valid, cmd, row_index, col_index, cell_in, output ready);
endinterface

@@ src/lgge_out_if.sv @@
// ----------------------------------------------------------------------------
// lgge_out_if
// Result item channel: cell value returned by a read.
// ----------------------------------------------------------------------------
interface lgge_out_if;
  logic valid;
  logic ready;
  logic cell_out;

  modport source (output valid, cell_out, input ready);
  modport sink   (input valid, cell_out, output ready);
endinterface

@@ src/lgge_ram.sv @@
// ----------------------------------------------------------------------------
// lgge_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lgge_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

@@ src/lgge_ctrl.sv @@
// ----------------------------------------------------------------------------
// lgge_ctrl
// Controller: sequences clearing, cell access and generation steps.
// ----------------------------------------------------------------------------
module lgge_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic [lgge_pkg::CmdW-1:0] in_cmd_i,
  output logic                     in_ready_o,
  output lgge_pkg::dp_cmd_t        dp_cmd_o,
  input  lgge_pkg::dp_stat_t       dp_stat_i
);
  import lgge_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (dp_stat_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          case (cmd_e'(in_cmd_i))
            CMD_WRITE:   state_d = ST_WRITE;
            CMD_READ:    state_d = ST_READ;
            CMD_ADVANCE: begin
              if (!dp_stat_i.rows_zero) state_d = ST_ADV_FILL;
            end
            default:     state_d = ST_IDLE;
          endcase
        end
      end
      ST_WRITE:    state_d = ST_IDLE;
      ST_READ: begin
        if (!dp_stat_i.out_busy) state_d = ST_IDLE;
      end
      ST_ADV_FILL: state_d = ST_ADV_ROW;
      ST_ADV_ROW: begin
        if (dp_stat_i.row_last) state_d = ST_IDLE;
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    dp_cmd_o   = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: dp_cmd_o.clr_step = 1'b1;
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (cmd_e'(in_cmd_i))
            CMD_WRITE, CMD_READ: dp_cmd_o.in_take = 1'b1;
            CMD_ADVANCE:         dp_cmd_o.adv_start = !dp_stat_i.rows_zero;
            default:             dp_cmd_o = '0;
          endcase
        end
      end
      ST_WRITE:    dp_cmd_o.acc_write = 1'b1;
      ST_READ:     dp_cmd_o.acc_read = !dp_stat_i.out_busy;
      ST_ADV_FILL: dp_cmd_o.adv_fill = 1'b1;
      ST_ADV_ROW:  dp_cmd_o.adv_row = 1'b1;
      default:     dp_cmd_o = '0;
    endcase
  end
endmodule

@@ src/lgge_dp.sv @@
// ----------------------------------------------------------------------------
// lgge_dp
// Datapath: grid memory, row buffers, next-generation logic, result register.
// ----------------------------------------------------------------------------
module lgge_dp #(
  parameter int MAX_ROWS = lgge_pkg::MaxRowsDef,
  parameter int MAX_COLS = lgge_pkg::MaxColsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [lgge_pkg::CountW-1:0] row_count_i,
  input  logic [lgge_pkg::CountW-1:0] col_count_i,
  input  logic [lgge_pkg::IdxW-1:0]   row_index_i,
  input  logic [lgge_pkg::IdxW-1:0]   col_index_i,
  input  logic                        cell_in_i,
  input  lgge_pkg::dp_cmd_t           dp_cmd_i,
  output lgge_pkg::dp_stat_t          dp_stat_o,
  output logic                        out_valid_o,
  output logic                        cell_out_o,
  input  logic                        out_ready_i
);
  import lgge_pkg::*;

  localparam int RowAw    = $clog2(MAX_ROWS);
  localparam int ColAw    = $clog2(MAX_COLS);
  localparam int RowCmpW  = (CountW > RowAw + 2) ? CountW : RowAw + 2;
  localparam int ColCmpW  = (CountW > ColAw + 2) ? CountW : ColAw + 2;
  localparam logic [3:0] BirthCnt = 4'd3;
  localparam logic [3:0] StayCnt  = 4'd2;

  // Size in use, clamped to the grid
  logic [RowCmpW-1:0] used_rows;
  logic [ColCmpW-1:0] used_cols;
  logic [RowCmpW-1:0] row_ext, cnt_ext, cnt_next1, cnt_next2;
  logic [ColCmpW-1:0] col_ext;
  logic               in_inside;
  logic [MAX_COLS-1:0] col_mask;

  assign used_rows = (RowCmpW'(row_count_i) > RowCmpW'(MAX_ROWS)) ?
                     RowCmpW'(MAX_ROWS) : RowCmpW'(row_count_i);
  assign used_cols = (ColCmpW'(col_count_i) > ColCmpW'(MAX_COLS)) ?
                     ColCmpW'(MAX_COLS) : ColCmpW'(col_count_i);
  assign row_ext   = RowCmpW'(row_index_i);
  assign col_ext   = ColCmpW'(col_index_i);
  assign in_inside = (row_ext < used_rows) && (col_ext < used_cols);

  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      col_mask[c] = ColCmpW'(c) < used_cols;
    end
  end

  // Row counter and latched access fields
  logic [RowAw-1:0]    row_cnt_q;
  logic [RowAw-1:0]    acc_row_q;
  logic [ColAw-1:0]    acc_col_q;
  logic                acc_val_q;
  logic                acc_inside_q;
  logic [MAX_COLS-1:0] above_q, cur_q;

  assign cnt_ext   = RowCmpW'(row_cnt_q);
  assign cnt_next1 = cnt_ext + RowCmpW'(1);
  assign cnt_next2 = cnt_ext + RowCmpW'(2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q <= '0;
    end else if (dp_cmd_i.adv_start) begin
      row_cnt_q <= '0;
    end else if (dp_cmd_i.clr_step || dp_cmd_i.adv_row) begin
      row_cnt_q <= row_cnt_q + RowAw'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.in_take) begin
      acc_row_q    <= RowAw'(row_ext);
      acc_col_q    <= ColAw'(col_ext);
      acc_val_q    <= cell_in_i;
      acc_inside_q <= in_inside;
    end
  end

  // Grid memory, one row per word
  logic                we, re;
  logic [RowAw-1:0]    waddr, raddr;
  logic [MAX_COLS-1:0] wdata, rdata;

  lgge_ram #(
    .Width (MAX_COLS),
    .Depth (MAX_ROWS)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Next generation of the current row
  logic [MAX_COLS-1:0] below;
  logic [MAX_COLS+1:0] pad_a, pad_m, pad_b;
  logic [3:0]          nb_cnt [MAX_COLS];
  logic [MAX_COLS-1:0] new_row;

  assign below = (cnt_next1 < used_rows) ? rdata : '0;
  assign pad_a = {1'b0, above_q & col_mask, 1'b0};
  assign pad_m = {1'b0, cur_q & col_mask, 1'b0};
  assign pad_b = {1'b0, below & col_mask, 1'b0};

  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      nb_cnt[c] = 4'(pad_a[c]) + 4'(pad_a[c+1]) + 4'(pad_a[c+2])
                + 4'(pad_m[c]) + 4'(pad_m[c+2])
                + 4'(pad_b[c]) + 4'(pad_b[c+1]) + 4'(pad_b[c+2]);
      if (col_mask[c]) begin
        new_row[c] = (nb_cnt[c] == BirthCnt) || (cur_q[c] && nb_cnt[c] == StayCnt);
      end else begin
        new_row[c] = cur_q[c];
      end
    end
  end

  // Old row buffers: shift down one row per step
  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.adv_fill) begin
      above_q <= '0;
      cur_q   <= rdata;
    end else if (dp_cmd_i.adv_row) begin
      above_q <= cur_q;
      cur_q   <= rdata;
    end
  end

  // Memory port selection
  logic [MAX_COLS-1:0] patched_row;

  always_comb begin
    patched_row            = rdata;
    patched_row[acc_col_q] = acc_val_q;
  end

  always_comb begin
    we    = 1'b0;
    waddr = row_cnt_q;
    wdata = '0;
    if (dp_cmd_i.clr_step) begin
      we = 1'b1;
    end else if (dp_cmd_i.acc_write) begin
      we    = acc_inside_q;
      waddr = acc_row_q;
      wdata = patched_row;
    end else if (dp_cmd_i.adv_row) begin
      we    = 1'b1;
      wdata = new_row;
    end
  end

  always_comb begin
    re    = 1'b0;
    raddr = '0;
    if (dp_cmd_i.in_take) begin
      re    = in_inside;
      raddr = RowAw'(row_ext);
    end else if (dp_cmd_i.adv_start) begin
      re = 1'b1;
    end else if (dp_cmd_i.adv_fill) begin
      re    = RowCmpW'(1) < used_rows;
      raddr = RowAw'(1);
    end else if (dp_cmd_i.adv_row) begin
      re    = cnt_next2 < used_rows;
      raddr = RowAw'(cnt_next2);
    end
  end

  // Result register
  logic out_valid_q, cell_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (dp_cmd_i.acc_read) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.acc_read) begin
      cell_out_q <= acc_inside_q && rdata[acc_col_q];
    end
  end

  assign out_valid_o = out_valid_q;
  assign cell_out_o  = cell_out_q;

  assign dp_stat_o.clr_last  = row_cnt_q == RowAw'(MAX_ROWS - 1);
  assign dp_stat_o.rows_zero = used_rows == '0;
  assign dp_stat_o.row_last  = cnt_next1 >= used_rows;
  assign dp_stat_o.out_busy  = out_valid_q && !out_ready_i;
endmodule

@@ src/life_grid_generation_engine_top.sv @@
// ----------------------------------------------------------------------------
// life_grid_generation_engine_top
// Game of life engine, rule B3/S23, on a configurable grid of one-bit cells.
// ----------------------------------------------------------------------------
// The grid holds MAX_ROWS rows of MAX_COLS cells, one memory word per row; the
// first row_count rows and col_count columns (APB registers at 0x0 and 0x4,
// reset 64) are in use, and cells outside count as dead and stay as they are.
// An item with cmd write sets one cell, cmd read returns one cell on the
// result channel (0 outside the size), cmd advance computes one generation
// with no wrap at the edges. After reset the block sweeps the memory to dead,
// one row per cycle, and takes no item until the sweep is done; configuration
// writes are taken meanwhile. A write or read first reads the memory, then
// writes back or loads the result register; a read waits while the result
// register is still full. An advance rewrites the rows in use in order: the
// single memory write port rewrites one row per cycle while two old rows sit in
// buffers and the row below streams from the read port. With no rows in use,
// an advance is taken and does nothing; so is an unused command.
// ----------------------------------------------------------------------------
module life_grid_generation_engine_top #(
  parameter int MAX_ROWS = lgge_pkg::MaxRowsDef,
  parameter int MAX_COLS = lgge_pkg::MaxColsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lgge_pkg::ApbAddrW-1:0] paddr,
  input  logic [lgge_pkg::ApbDataW-1:0] pwdata,
  output logic [lgge_pkg::ApbDataW-1:0] prdata,
  output logic                          pready,
  // Item channels
  lgge_in_if.sink                       in_i,
  lgge_out_if.source                    out_o
);
  import lgge_pkg::*;

  // Size registers
  logic [CountW-1:0] row_count_q, col_count_q;
  logic              cfg_wr;
  logic              reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[ApbAddrW-1];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= RowCountRst;
      col_count_q <= ColCountRst;
    end else if (cfg_wr) begin
      if (reg_sel == RegRowCount) begin
        row_count_q <= pwdata[CountW-1:0];
      end else begin
        col_count_q <= pwdata[CountW-1:0];
      end
    end
  end

  // Read back the addressed register
  assign prdata = (reg_sel == RegRowCount) ? ApbDataW'(row_count_q) : ApbDataW'(col_count_q);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  lgge_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_cmd_i   (in_i.cmd),
    .in_ready_o (in_i.ready),
    .dp_cmd_o   (dp_cmd),
    .dp_stat_i  (dp_stat)
  );

  lgge_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .row_count_i (row_count_q),
    .col_count_i (col_count_q),
    .row_index_i (in_i.row_index),
    .col_index_i (in_i.col_index),
    .cell_in_i   (in_i.cell_in),
    .dp_cmd_i    (dp_cmd),
    .dp_stat_o   (dp_stat),
    .out_valid_o (out_o.valid),
    .cell_out_o  (out_o.cell_out),
    .out_ready_i (out_o.ready)
  );
endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the life grid engine. A driver feeds cell writes,
// cell reads and generation steps from a queue. A local grid model predicts
// every read, and a monitor compares each returned cell with the oldest
// prediction. The grid size registers are swept between phases, across the
// extremes and the out-of-range cases.
// ----------------------------------------------------------------------------
module tb;
  import lgge_pkg::*;

  // Clock period and the long receiver hold-off, in ns and cycles
  localparam int ClkPeriod  = 8;
  localparam int LongHold   = 400;
  // Cycles to let a trailing generation step finish before a register write
  localparam int AdvSettle  = MaxRowsDef + 36;
  // Cap on the wait for the last cell results at the end of the run
  localparam int DrainLimit = 5000;
  // Hard stop for a hung run, in ns
  localparam int RunLimitNs = 8_000_000;

  // Command code that the block treats as a no-op
  localparam logic [CmdW-1:0] CmdUnused = 2'd3;

  // Byte addresses of the size registers
  localparam logic [ApbAddrW-1:0] AddrRowCount = ApbAddrW'(4 * int'(RegRowCount));
  localparam logic [ApbAddrW-1:0] AddrColCount = ApbAddrW'(4 * int'(RegColCount));

  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic [IdxW-1:0] row;
    logic [IdxW-1:0] col;
    logic            val;
  } grid_op_t;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  lgge_in_if  in_ch ();
  lgge_out_if out_ch ();

  life_grid_generation_engine_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_ch),
    .out_o   (out_ch)
  );

  // Grid model: full 64 x 64 array, cells outside the size keep their values
  logic [MaxColsDef-1:0] life_cells [MaxRowsDef];
  logic [CountW-1:0]     row_cfg;
  logic [CountW-1:0]     col_cfg;

  grid_op_t grid_ops [$];     // items still to be offered
  logic     cell_expect [$];  // predicted read results, oldest first

  int ops_sent;
  int ops_taken;
  int mismatches;
  logic in_fire;

  // Source side pacing
  int src_gap;
  int src_calm;
  // Sink side pacing
  int snk_gap;
  int snk_calm;
  int hold_req;
  int hold_ack;

  // --------------------------------------------------------------------------
  // Grid model
  // --------------------------------------------------------------------------
  function automatic int used_rows();
    return (row_cfg > MaxRowsDef) ? MaxRowsDef : int'(row_cfg);
  endfunction

  function automatic int used_cols();
    return (col_cfg > MaxColsDef) ? MaxColsDef : int'(col_cfg);
  endfunction

  // Rewrite the rows in use one by one; the row above comes from a saved copy
  // and the row below has not been rewritten yet, so every cell sees the old
  // generation. Columns past the size stay as they are.
  function automatic void advance_generation();
    int nr;
    int nc;
    int n;
    logic [MaxColsDef-1:0] above;
    logic [MaxColsDef-1:0] cur;
    logic [MaxColsDef-1:0] below;
    logic [MaxColsDef-1:0] next;
    nr    = used_rows();
    nc    = used_cols();
    above = '0;
    for (int r = 0; r < nr; r++) begin
      cur   = life_cells[r];
      below = (r + 1 < nr) ? life_cells[r + 1] : '0;
      next  = cur;
      for (int c = 0; c < nc; c++) begin
        n = 0;
        for (int dc = -1; dc <= 1; dc++) begin
          if (c + dc >= 0 && c + dc < nc) begin
            n += int'(above[c + dc]) + int'(below[c + dc]);
            if (dc != 0) n += int'(cur[c + dc]);
          end
        end
        next[c] = (n == 3) || (cur[c] && n == 2);
      end
      life_cells[r] = next;
      above         = cur;
    end
  endfunction

  // Apply one accepted item; a read pushes the cell it should return
  function automatic void apply_item(grid_op_t op);
    logic in_size;
    in_size = (int'(op.row) < used_rows()) && (int'(op.col) < used_cols());
    if (op.cmd == CMD_WRITE) begin
      if (in_size) life_cells[op.row][op.col] = op.val;
    end else if (op.cmd == CMD_ADVANCE) begin
      advance_generation();
    end else if (op.cmd == CMD_READ) begin
      cell_expect.push_back(in_size ? life_cells[op.row][op.col] : 1'b0);
    end
  endfunction

  function automatic void note_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t ns: %s", $time, what);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void queue_op(logic [CmdW-1:0] cmd, int r, int c, logic v);
    grid_ops.push_back('{cmd: cmd, row: IdxW'(r), col: IdxW'(c), val: v});
  endfunction

  // Mostly well-formed patterns: seed a small window, step it a few times and
  // read around it; the rest is noise with any command and any index.
  function automatic void queue_random_phase(int target);
    int done_cnt;
    int nr;
    int nc;
    int ar;
    int ac;
    int n;
    logic [CmdW-1:0] cmd;
    done_cnt = 0;
    nr       = used_rows();
    nc       = used_cols();
    while (done_cnt < target) begin
      if ($urandom_range(0, 99) < 85) begin
        ar = (nr > 0) ? $urandom_range(0, nr - 1) : $urandom_range(0, 63);
        ac = (nc > 0) ? $urandom_range(0, nc - 1) : $urandom_range(0, 63);
        n  = $urandom_range(1, 14);
        repeat (n) begin
          queue_op(CMD_WRITE, (ar + $urandom_range(0, 3)) % 64,
                   (ac + $urandom_range(0, 3)) % 64, $urandom_range(0, 99) < 65);
          done_cnt++;
        end
        n = $urandom_range(1, 3);
        repeat (n) begin
          queue_op(CMD_ADVANCE, $urandom_range(0, 63), $urandom_range(0, 63),
                   $urandom_range(0, 1));
          done_cnt++;
        end
        n = $urandom_range(2, 10);
        repeat (n) begin
          if ($urandom_range(0, 9) == 0) begin
            queue_op(CMD_READ, $urandom_range(0, 63), $urandom_range(0, 63),
                     $urandom_range(0, 1));
          end else begin
            queue_op(CMD_READ, (ar + $urandom_range(0, 5)) % 64,
                     (ac + $urandom_range(0, 5)) % 64, $urandom_range(0, 1));
          end
          done_cnt++;
        end
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          cmd = CmdW'($urandom_range(0, 3));
          queue_op(cmd, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 1));
          if (cmd != CmdUnused) done_cnt++;
        end
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  task automatic apb_write(input logic [ApbAddrW-1:0] addr, input logic [ApbDataW-1:0] data);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic apb_read_check(input logic [ApbAddrW-1:0] addr,
                                input logic [ApbDataW-1:0] want);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = addr;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== want) begin
      note_mismatch($sformatf("register 0x%0h read: expected 0x%0h got 0x%0h",
                              addr, want, prdata));
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Write both size registers, mirror them in the model and read them back
  task automatic set_grid_size(input int rows, input int cols);
    apb_write(AddrRowCount, ApbDataW'(rows));
    apb_write(AddrColCount, ApbDataW'(cols));
    row_cfg = CountW'(rows);
    col_cfg = CountW'(cols);
    apb_read_check(AddrRowCount, ApbDataW'(row_cfg));
    apb_read_check(AddrColCount, ApbDataW'(col_cfg));
  endtask

  // Hold off new items until every offered one is taken and every read has
  // returned, then let a trailing generation step run out.
  task automatic wait_idle();
    while (grid_ops.size() != 0 || ops_sent != ops_taken || cell_expect.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (AdvSettle) @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial clk_i = 1'b0;
  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Driver: offer the next item at the falling edge once the last one is taken
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : drive_items
    grid_op_t op;
    if (rst_ni && (!in_ch.valid || in_fire)) begin
      if (src_gap > 0) begin
        // idle the channel for the rest of the gap
        src_gap <= src_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (grid_ops.size() > 0) begin
        op = grid_ops.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.cmd       <= op.cmd;
        in_ch.row_index <= op.row;
        in_ch.col_index <= op.col;
        in_ch.cell_in   <= op.val;
        ops_sent++;
        // pick the gap after this item: none during a calm stretch
        if (src_calm > 0) begin
          src_calm--;
          src_gap <= 0;
        end else if ($urandom_range(0, 99) < 4) begin
          src_calm = $urandom_range(40, 120);
          src_gap <= 0;
        end else if ($urandom_range(0, 99) < 60) begin
          src_gap <= 0;
        end else if ($urandom_range(0, 99) < 80) begin
          src_gap <= $urandom_range(1, 3);
        end else if ($urandom_range(0, 99) < 90) begin
          src_gap <= $urandom_range(4, 12);
        end else begin
          src_gap <= $urandom_range(30, 80);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result sink: random stalls, calm stretches, and the long hold-off on
  // request, counted here in cycles
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      snk_gap  = LongHold - 1;
      out_ch.ready <= 1'b0;
    end else if (snk_gap > 0) begin
      snk_gap--;
      out_ch.ready <= 1'b0;
    end else if (snk_calm > 0) begin
      snk_calm--;
      out_ch.ready <= 1'b1;
    end else if ($urandom_range(0, 99) < 3) begin
      snk_calm = $urandom_range(50, 150);
      out_ch.ready <= 1'b1;
    end else if ($urandom_range(0, 99) < 70) begin
      out_ch.ready <= 1'b1;
    end else begin
      // stall: mostly short, now and then long
      if ($urandom_range(0, 99) < 80) snk_gap = $urandom_range(0, 2);
      else if ($urandom_range(0, 99) < 85) snk_gap = $urandom_range(3, 11);
      else snk_gap = $urandom_range(29, 79);
      out_ch.ready <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check returned cells first, then predict the item taken this edge
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch_channels
    grid_op_t op;
    logic     want;
    if (!rst_ni) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_ch.valid && in_ch.ready;
      if (out_ch.valid && out_ch.ready) begin
        if (cell_expect.size() == 0) begin
          note_mismatch($sformatf("cell result %b with no read pending", out_ch.cell_out));
        end else begin
          want = cell_expect.pop_front();
          if (out_ch.cell_out !== want) begin
            note_mismatch($sformatf("cell_out: expected %b got %b", want, out_ch.cell_out));
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        op = '{cmd: in_ch.cmd, row: in_ch.row_index, col: in_ch.col_index,
               val: in_ch.cell_in};
        apply_item(op);
        ops_taken++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Run limit
  // --------------------------------------------------------------------------
  initial begin
    #(RunLimitNs);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sequence of phases
  // --------------------------------------------------------------------------
  initial begin : run_phases
    int waited;
    // drive every input to a known value before the first edge
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_ch.valid     = 1'b0;
    in_ch.cmd       = CMD_WRITE;
    in_ch.row_index = '0;
    in_ch.col_index = '0;
    in_ch.cell_in   = 1'b0;
    out_ch.ready    = 1'b0;
    ops_sent        = 0;
    ops_taken       = 0;
    mismatches      = 0;
    src_gap         = 0;
    src_calm        = 0;
    snk_gap         = 0;
    snk_calm        = 0;
    hold_req        = 0;
    hold_ack        = 0;
    in_fire         = 1'b0;
    row_cfg         = RowCountRst;
    col_cfg         = ColCountRst;
    for (int r = 0; r < MaxRowsDef; r++) life_cells[r] = '0;

    // hold reset, then release it at a falling edge
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Full size; the register writes land during the clearing pass
    set_grid_size(64, 64);
    // corners start dead
    queue_op(CMD_READ, 0, 0, 1'b0);
    queue_op(CMD_READ, 63, 63, 1'b1);
    // set both corners, read them back, then kill one by writing 0
    queue_op(CMD_WRITE, 0, 0, 1'b1);
    queue_op(CMD_WRITE, 63, 63, 1'b1);
    queue_op(CMD_READ, 0, 0, 1'b0);
    queue_op(CMD_READ, 63, 63, 1'b0);
    queue_op(CMD_WRITE, 63, 63, 1'b0);
    queue_op(CMD_READ, 63, 63, 1'b0);
    // unused command must leave the grid alone
    queue_op(CmdUnused, 0, 0, 1'b0);
    queue_op(CMD_READ, 0, 0, 1'b0);
    // vertical blinker turns horizontal; the lone corner cell dies
    queue_op(CMD_WRITE, 1, 10, 1'b1);
    queue_op(CMD_WRITE, 2, 10, 1'b1);
    queue_op(CMD_WRITE, 3, 10, 1'b1);
    queue_op(CMD_ADVANCE, 0, 0, 1'b0);
    queue_op(CMD_READ, 2, 9, 1'b0);
    queue_op(CMD_READ, 2, 11, 1'b0);
    queue_op(CMD_READ, 1, 10, 1'b0);
    queue_op(CMD_READ, 0, 0, 1'b0);
    queue_random_phase(110);
    wait_idle();

    // Smallest grid: one cell, and writes next to it fall outside
    set_grid_size(1, 1);
    queue_op(CMD_WRITE, 0, 0, 1'b1);
    queue_op(CMD_WRITE, 0, 1, 1'b1);
    queue_op(CMD_READ, 0, 1, 1'b0);
    queue_op(CMD_ADVANCE, 0, 0, 1'b0);
    queue_op(CMD_READ, 0, 0, 1'b0);
    queue_random_phase(60);
    wait_idle();

    // No rows in use: writes dropped, reads give dead, steps do nothing
    set_grid_size(0, 5);
    queue_op(CMD_WRITE, 0, 0, 1'b1);
    queue_op(CMD_READ, 0, 0, 1'b1);
    queue_random_phase(50);
    wait_idle();

    // Oversized counts act as the full grid
    set_grid_size(127, 127);
    queue_random_phase(120);
    wait_idle();

    set_grid_size(3, 64);
    queue_random_phase(110);
    wait_idle();

    set_grid_size(64, 3);
    queue_random_phase(110);
    wait_idle();

    // Long receiver hold-off while the driver keeps offering items, so the
    // result register fills and reads back up the input channel
    set_grid_size(8, 8);
    hold_req++;
    for (int i = 0; i < 20; i++) begin
      queue_op(CMD_READ, $urandom_range(0, 9), $urandom_range(0, 9), $urandom_range(0, 1));
    end
    queue_random_phase(110);
    wait_idle();

    set_grid_size(5, 12);
    queue_random_phase(110);
    wait_idle();

    // No columns in use, rows at the maximum
    set_grid_size(64, 0);
    queue_random_phase(40);
    wait_idle();

    set_grid_size(64, 64);
    queue_random_phase(110);

    // Drain: everything taken, then the last cell results with a bound
    while (grid_ops.size() != 0 || ops_sent != ops_taken) @(negedge clk_i);
    waited = 0;
    while (cell_expect.size() != 0 && waited < DrainLimit) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (AdvSettle) @(negedge clk_i);
    if (cell_expect.size() != 0) begin
      note_mismatch($sformatf("%0d cell results never returned", cell_expect.size()));
    end

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/lgge_pkg.sv
src/lgge_in_if.sv
src/lgge_out_if.sv
src/lgge_ram.sv
src/lgge_ctrl.sv
src/lgge_dp.sv
src/life_grid_generation_engine_top.sv
bench/tb.sv
